FILE: rtl/assert_macros.svh
// Assertion macros used by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/kld_pkg.sv
// Keyword tables, language codes and match helpers for the language detector.
package kld_pkg;

  localparam int KEYWORDS_PER_LANGUAGE = 6;
  localparam int MAX_KEYWORD_BYTES     = 3;
  localparam int LANG_COUNT            = 5;

  localparam int WIN_BITS  = 8 * MAX_KEYWORD_BYTES;
  localparam int HIST_BITS = 8 * (MAX_KEYWORD_BYTES - 1);
  localparam int LEN_W     = $clog2(MAX_KEYWORD_BYTES + 1);
  localparam int SCORE_W   = 3;
  localparam int LANG_W    = 3;

  typedef logic [WIN_BITS-1:0]              kw_pat_t;
  typedef logic [LEN_W-1:0]                 kw_len_t;
  typedef logic [SCORE_W-1:0]               score_t;
  typedef logic [KEYWORDS_PER_LANGUAGE-1:0] kw_flags_t;

  typedef enum logic [LANG_W-1:0] {
    LANG_ENGLISH  = 3'd0,
    LANG_SPANISH  = 3'd1,
    LANG_FRENCH   = 3'd2,
    LANG_GERMAN   = 3'd3,
    LANG_CHINESE  = 3'd4,
    LANG_JAPANESE = 3'd5
  } lang_t;

  // Patterns are right aligned: last keyword byte in bits 7..0.
  localparam kw_pat_t KW_PATTERN [LANG_COUNT][KEYWORDS_PER_LANGUAGE] = '{
    '{24'h00656C, 24'h006C61, 24'h006465, 24'h00656E, 24'h000079, 24'h717565},
    '{24'h006C65, 24'h006C61, 24'h006465, 24'h006574, 24'h657374, 24'h717565},
    '{24'h646572, 24'h646965, 24'h756E64, 24'h007A75, 24'h64656E, 24'h646173},
    '{24'hE79A84, 24'hE698AF, 24'hE59CA8, 24'hE5928C, 24'hE4BA86, 24'hE69C89},
    '{24'hE381AE, 24'hE381AF, 24'hE38292, 24'hE3818C, 24'hE381AB, 24'hE381A8}
  };

  localparam kw_len_t KW_LENGTH [LANG_COUNT][KEYWORDS_PER_LANGUAGE] = '{
    '{2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd3},
    '{2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3},
    '{2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3},
    '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
    '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3}
  };

  // True when the keyword's bytes end at the newest byte of the window.
  function automatic logic kw_match(kw_pat_t window, kw_pat_t pat, kw_len_t len);
    kw_pat_t mask;
    mask = '0;
    for (int i = 0; i < MAX_KEYWORD_BYTES; i++) begin
      if (i < int'(len)) begin
        mask[8*i +: 8] = 8'hFF;
      end
    end
    return (len != '0) && ((window & mask) == pat);
  endfunction

  // Distinct keywords found; wraps to the field width like the score port.
  function automatic score_t kw_count(kw_flags_t flags);
    score_t c;
    c = '0;
    for (int i = 0; i < KEYWORDS_PER_LANGUAGE; i++) begin
      c = c + score_t'(flags[i]);
    end
    return c;
  endfunction

endpackage

FILE: rtl/keyword_language_detector.sv
// A transferred byte is matched from the input register; a final byte's result
//   loads into the output register when that byte is consumed.
// Throughput: one byte per cycle. Input stalls only while the input register holds a
//   final byte and the output register still holds an untaken result.
// Reset (synchronous, rst_n low): clears the pipeline valids, the byte history
//   and all found flags; payload registers are left as they are.
module keyword_language_detector
  import kld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // byte stream
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_text,
  // per-message result
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LANG_W-1:0] out_detected_language,
  output logic [2:0]        out_winning_score,
  output logic [2:0]        out_spanish_score,
  output logic [2:0]        out_french_score,
  output logic [2:0]        out_german_score,
  output logic [2:0]        out_chinese_score,
  output logic [2:0]        out_japanese_score
);

`include "assert_macros.svh"

  // ---------------------------------------------------------------------------
  // Input register: one byte plus its end-of-message mark.
  // ---------------------------------------------------------------------------
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eot_r;

  // Match state: previous bytes (newest low) and one sticky flag per keyword.
  logic [HIST_BITS-1:0]  hist_r, hist_nxt;
  kw_flags_t             seen_r   [LANG_COUNT];
  kw_flags_t             seen_nxt [LANG_COUNT];

  // Output register.
  logic   out_valid_r, out_valid_nxt;
  lang_t  out_lang_r;
  score_t out_win_r;
  score_t out_score_r [LANG_COUNT];

  logic    in_xfer;     // byte transferred into the input register
  logic    out_xfer;    // result transferred out
  logic    out_free;    // output register can take a result this cycle
  logic    s1_adv;      // byte in the input register is consumed this cycle
  logic    res_load;    // final byte consumed, result loads

  kw_pat_t   window;
  kw_flags_t hit     [LANG_COUNT];
  kw_flags_t seen_or [LANG_COUNT];
  score_t    score   [LANG_COUNT];
  lang_t     best_lang;
  score_t    best_score;

  // ---------------------------------------------------------------------------
  // Handshake. Ordinary bytes always drain; a final byte waits for the output
  // register to be empty or emptying in the same cycle.
  // ---------------------------------------------------------------------------
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_eot_r || out_free);
  assign res_load = s1_adv && s1_eot_r;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_text_byte;
      s1_eot_r  <= in_end_of_text;
    end
  end

  // ---------------------------------------------------------------------------
  // Keyword compare: all thirty patterns against the window in parallel.
  // ---------------------------------------------------------------------------
  assign window = {hist_r, s1_byte_r};

  always_comb begin
    for (int l = 0; l < LANG_COUNT; l++) begin
      for (int k = 0; k < KEYWORDS_PER_LANGUAGE; k++) begin
        hit[l][k] = kw_match(window, KW_PATTERN[l][k], KW_LENGTH[l][k]);
      end
      seen_or[l] = seen_r[l] | hit[l];
    end
  end

  // History and flags advance per consumed byte; a final byte clears them so
  // nothing carries into the next message.
  always_comb begin
    hist_nxt = hist_r;
    for (int l = 0; l < LANG_COUNT; l++) begin
      seen_nxt[l] = seen_r[l];
    end
    if (s1_adv) begin
      if (s1_eot_r) begin
        hist_nxt = '0;
        for (int l = 0; l < LANG_COUNT; l++) begin
          seen_nxt[l] = '0;
        end
      end else begin
        hist_nxt = window[HIST_BITS-1:0];
        for (int l = 0; l < LANG_COUNT; l++) begin
          seen_nxt[l] = seen_or[l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      for (int l = 0; l < LANG_COUNT; l++) begin
        seen_r[l] <= '0;
      end
    end else begin
      hist_r <= hist_nxt;
      for (int l = 0; l < LANG_COUNT; l++) begin
        seen_r[l] <= seen_nxt[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoring: popcount per language, then a strict-greater scan so a tie keeps
  // the earlier language and all-zero leaves english.
  // ---------------------------------------------------------------------------
  always_comb begin
    best_lang  = LANG_ENGLISH;
    best_score = '0;
    for (int l = 0; l < LANG_COUNT; l++) begin
      score[l] = kw_count(seen_or[l]);
      if (score[l] > best_score) begin
        best_score = score[l];
        best_lang  = lang_t'(LANG_W'(l + 1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_lang_r <= best_lang;
      out_win_r  <= best_score;
      for (int l = 0; l < LANG_COUNT; l++) begin
        out_score_r[l] <= score[l];
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_detected_language = out_lang_r;
  assign out_winning_score     = out_win_r;
  assign out_spanish_score     = out_score_r[0];
  assign out_french_score      = out_score_r[1];
  assign out_german_score      = out_score_r[2];
  assign out_chinese_score     = out_score_r[3];
  assign out_japanese_score    = out_score_r[4];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r && !s1_valid_r && hist_r == '0, "reset did not clear control state")
  `ASSERT_CLK(a_eot_clears, res_load |=> hist_r == '0 && seen_r[0] == '0 && seen_r[4] == '0, "match state not cleared after final byte")
  `ASSERT_CLK(a_rose_from_eot, $rose(out_valid_r) |-> $past(res_load), "result appeared without a final byte")
  `ASSERT_CLK(a_english_zero, out_valid_r |-> ((out_lang_r == LANG_ENGLISH) == (out_win_r == '0)), "english winner and zero score disagree")
  `ASSERT_CLK(a_win_is_max, out_valid_r |-> out_win_r >= out_score_r[0] && out_win_r >= out_score_r[1] && out_win_r >= out_score_r[2] && out_win_r >= out_score_r[3] && out_win_r >= out_score_r[4], "winning score below a language score")

endmodule

FILE: dv/keyword_language_detector_test.sv
// Self-checking testbench for the keyword language detector: byte stream in, per-message verdicts out.
module keyword_language_detector_test;
  import kld_pkg::*;

  // Run limits in clock cycles, and stimulus sizes.
  localparam int LIMIT_CYCLES  = 200000;  // hard stop, far above the slowest legal run
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off in the pressure phase
  localparam int DRAIN_CYCLES  = 2000;    // max wait for outstanding verdicts
  localparam int TAIL_CYCLES   = 8;       // extra wait for stray outputs after the drain
  localparam int TOTAL_BYTES   = 950;
  localparam int DIRECTED_ROWS = 22;

  // One per-message verdict, laid out like the result ports.
  typedef struct packed {
    lang_t      lang;
    logic [2:0] win;
    logic [2:0] sp;
    logic [2:0] fr;
    logic [2:0] ge;
    logic [2:0] zh;
    logic [2:0] ja;
  } verdict_t;

  // Directed stimulus row. When typed is set the verdict is the hand-written one,
  // otherwise the tracker below supplies it.
  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       typed;
    verdict_t   verdict;
  } dir_row_t;

  localparam verdict_t ENGLISH_NONE = '{LANG_ENGLISH, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};

  // Keyword dictionary, right aligned: final keyword byte in bits 7..0.
  // Rows: spanish, french, german, chinese, japanese (UTF-8 for the last two).
  localparam logic [23:0] WORD_BITS [LANG_COUNT][KEYWORDS_PER_LANGUAGE] = '{
    '{24'h00656C, 24'h006C61, 24'h006465, 24'h00656E, 24'h000079, 24'h717565},
    '{24'h006C65, 24'h006C61, 24'h006465, 24'h006574, 24'h657374, 24'h717565},
    '{24'h646572, 24'h646965, 24'h756E64, 24'h007A75, 24'h64656E, 24'h646173},
    '{24'hE79A84, 24'hE698AF, 24'hE59CA8, 24'hE5928C, 24'hE4BA86, 24'hE69C89},
    '{24'hE381AE, 24'hE381AF, 24'hE38292, 24'hE3818C, 24'hE381AB, 24'hE381A8}
  };
  localparam int WORD_LEN [LANG_COUNT][KEYWORDS_PER_LANGUAGE] = '{
    '{2, 2, 2, 2, 1, 3},
    '{2, 2, 2, 2, 3, 3},
    '{3, 3, 3, 2, 3, 3},
    '{3, 3, 3, 3, 3, 3},
    '{3, 3, 3, 3, 3, 3}
  };

  // Filler bytes that sit close to keywords, plus UTF-8 lead and continuation bytes for near misses.
  localparam logic [7:0] NEAR_BYTES [14] = '{
    "d", "e", "l", "n", "q", "s", "t", "u", "y", "z", "a", "i", 8'hE3, 8'h81
  };

  // Directed part: field extremes, one of each language, the tie rule, the
  // english fallback, and a keyword split across two messages.
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // lowest and highest byte as one-byte messages: no keyword, english
    '{8'h00, 1'b1, 1'b1, ENGLISH_NONE},
    '{8'hFF, 1'b1, 1'b1, ENGLISH_NONE},
    // single-byte spanish keyword
    '{8'h79, 1'b1, 1'b1, '{LANG_SPANISH, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0}},
    // "que" is in spanish and french: tie goes to spanish
    '{8'h71, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h75, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h65, 1'b1, 1'b1, '{LANG_SPANISH, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0}},
    // "est": french only
    '{8'h65, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h73, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h74, 1'b1, 1'b1, '{LANG_FRENCH, 3'd1, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0}},
    // "zu": german
    '{8'h7A, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h75, 1'b1, 1'b1, '{LANG_GERMAN, 3'd1, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0}},
    // chinese three-byte keyword
    '{8'hE7, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h9A, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h84, 1'b1, 1'b1, '{LANG_CHINESE, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0}},
    // japanese three-byte keyword
    '{8'hE3, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h81, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'hAE, 1'b1, 1'b1, '{LANG_JAPANESE, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1}},
    // "den" hits three languages at once; tracker decides
    '{8'h64, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h65, 1'b0, 1'b0, ENGLISH_NONE},
    '{8'h6E, 1'b1, 1'b0, ENGLISH_NONE},
    // "la" split over two messages must not match
    '{8'h6C, 1'b1, 1'b1, ENGLISH_NONE},
    '{8'h61, 1'b1, 1'b1, ENGLISH_NONE}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_text_byte = 8'h00;
  logic              in_end_of_text = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LANG_W-1:0] out_detected_language;
  logic [2:0]        out_winning_score;
  logic [2:0]        out_spanish_score;
  logic [2:0]        out_french_score;
  logic [2:0]        out_german_score;
  logic [2:0]        out_chinese_score;
  logic [2:0]        out_japanese_score;

  // Tracker state: last two message bytes (newest low) and sticky found flags.
  logic [15:0]                      recent_bytes = '0;
  logic [KEYWORDS_PER_LANGUAGE-1:0] words_found [LANG_COUNT] = '{default: '0};

  verdict_t verdicts_due[$];   // verdicts owed by the block, oldest first
  int       mismatches = 0;
  int       bytes_sent = 0;
  int       cycle_count = 0;
  bit       gaps_on = 1'b0;     // sender may pause between transfers
  bit       stalls_on = 1'b0;   // receiver may stall in short bursts
  bit       hold_req = 1'b0;    // receiver does one long hold-off

  keyword_language_detector dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_text_byte          (in_text_byte),
    .in_end_of_text        (in_end_of_text),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_detected_language (out_detected_language),
    .out_winning_score     (out_winning_score),
    .out_spanish_score     (out_spanish_score),
    .out_french_score      (out_french_score),
    .out_german_score      (out_german_score),
    .out_chinese_score     (out_chinese_score),
    .out_japanese_score    (out_japanese_score)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Updates the tracker with one byte. On the final byte of a message it
  // returns 1 with the verdict and clears flags and history.
  function automatic bit track_keywords(input logic [7:0] b, input logic last,
                                        output verdict_t v);
    logic [23:0] window;
    logic [23:0] mask;
    logic [2:0]  tally [LANG_COUNT];
    window = {recent_bytes, b};
    for (int l = 0; l < LANG_COUNT; l++) begin
      for (int k = 0; k < KEYWORDS_PER_LANGUAGE; k++) begin
        mask = 24'hFFFFFF >> (8 * (3 - WORD_LEN[l][k]));
        if ((window & mask) == WORD_BITS[l][k]) begin
          words_found[l][k] = 1'b1;
        end
      end
    end
    recent_bytes = window[15:0];
    v = ENGLISH_NONE;
    if (!last) begin
      return 1'b0;
    end
    // strictly higher count wins, so a tie stays with the earlier language
    for (int l = 0; l < LANG_COUNT; l++) begin
      tally[l] = '0;
      for (int k = 0; k < KEYWORDS_PER_LANGUAGE; k++) begin
        tally[l] = tally[l] + 3'(words_found[l][k]);
      end
      if (tally[l] > v.win) begin
        v.win  = tally[l];
        v.lang = lang_t'(l + 1);
      end
    end
    v.sp = tally[0];
    v.fr = tally[1];
    v.ge = tally[2];
    v.zh = tally[3];
    v.ja = tally[4];
    recent_bytes = '0;
    for (int l = 0; l < LANG_COUNT; l++) begin
      words_found[l] = '0;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Offers one byte and holds it until transferred. The verdict, if the byte
  // ends a message, is queued in transfer order. Then maybe a sender gap.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input verdict_t typed_v);
    verdict_t v;
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= last;
    do @(posedge clk); while (in_stall);
    if (track_keywords(b, last, v)) begin
      verdicts_due.insert(verdicts_due.size(), typed ? typed_v : v);
    end
    bytes_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Builds and sends one message. Mostly keyword-rich text; some pure noise,
  // some truncated keywords, some with a whole language's dictionary.
  // short_only keeps messages to one piece (at most three bytes).
  task automatic send_random_message(input bit short_only);
    logic [7:0] text_q[$];
    int         kind;
    int         l;
    int         k;
    int         n;
    kind = short_only ? 9 : $urandom_range(0, 9);
    if (kind == 0) begin
      // noise
      n = $urandom_range(1, 8);
      repeat (n) text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      // every keyword of one language: drives that score to six
      l = $urandom_range(0, LANG_COUNT - 1);
      for (k = 0; k < KEYWORDS_PER_LANGUAGE; k++) begin
        for (int i = WORD_LEN[l][k] - 1; i >= 0; i--) begin
          text_q.insert(text_q.size(), WORD_BITS[l][k][8*i +: 8]);
        end
        if ($urandom_range(0, 1) == 0) begin
          text_q.insert(text_q.size(), 8'h20);
        end
      end
    end else if (kind == 2) begin
      // keyword cut short, then a random byte
      l = $urandom_range(0, LANG_COUNT - 1);
      k = $urandom_range(0, KEYWORDS_PER_LANGUAGE - 1);
      n = $urandom_range(0, WORD_LEN[l][k] - 1);
      for (int i = WORD_LEN[l][k] - 1; i >= WORD_LEN[l][k] - n; i--) begin
        text_q.insert(text_q.size(), WORD_BITS[l][k][8*i +: 8]);
      end
      text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
    end else begin
      n = short_only ? 1 : $urandom_range(1, 5);
      repeat (n) begin
        k = $urandom_range(0, 9);
        if (k < 6) begin
          l = $urandom_range(0, LANG_COUNT - 1);
          k = $urandom_range(0, KEYWORDS_PER_LANGUAGE - 1);
          for (int i = WORD_LEN[l][k] - 1; i >= 0; i--) begin
            text_q.insert(text_q.size(), WORD_BITS[l][k][8*i +: 8]);
          end
        end else if (k < 8) begin
          text_q.insert(text_q.size(), NEAR_BYTES[$urandom_range(0, 13)]);
        end else if (k == 8) begin
          text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end else begin
          text_q.insert(text_q.size(), 8'h20);
        end
      end
    end
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1, 1'b0, ENGLISH_NONE);
    end
  endtask

  // Sender goes quiet until every owed verdict is in or the drain limit is reached.
  // It always waits on a clock edge first so in_valid is never lowered and raised in the same step.
  task automatic drain_verdicts();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (verdicts_due.size() != 0 && waited < DRAIN_CYCLES);
    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $time, verdicts_due.size());
      mismatches++;
      verdicts_due.delete();
    end
  endtask

  // Result side: compare each transfer against the oldest owed verdict.
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual language %0d",
                 $time, out_detected_language);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        check_field("detected_language", want.lang, out_detected_language);
        check_field("winning_score", want.win, out_winning_score);
        check_field("spanish_score", want.sp, out_spanish_score);
        check_field("french_score", want.fr, out_french_score);
        check_field("german_score", want.ge, out_german_score);
        check_field("chinese_score", want.zh, out_chinese_score);
        check_field("japanese_score", want.ja, out_japanese_score);
      end
    end
  end

  // Receiver: short random stall bursts, or one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n     <= 1'b1;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_byte(DIRECTED[row].text, DIRECTED[row].last, DIRECTED[row].typed,
                DIRECTED[row].verdict);
    end

    while (bytes_sent < 400) send_random_message(1'b0);

    // Pressure: sender pauses for a full drain, then the receiver holds off
    // while back-to-back short messages fill the block and stall its input.
    drain_verdicts();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_random_message(1'b1);
    drain_verdicts();
    gaps_on = 1'b1;

    while (bytes_sent < 800) send_random_message(1'b0);

    // Last stretch at full rate on both sides.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (bytes_sent < TOTAL_BYTES) send_random_message(1'b0);

    drain_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/kld_pkg.sv
rtl/keyword_language_detector.sv
dv/keyword_language_detector_test.sv
